// ===== design/rgb565_framebuffer_blend_fill_shift_assert.svh =====
// Assertion macros for the frame engine.
`ifndef RGB565_FRAMEBUFFER_BLEND_FILL_SHIFT_ASSERT_SVH
`define RGB565_FRAMEBUFFER_BLEND_FILL_SHIFT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/fbe_pkg.sv =====
package fbe_pkg;
  localparam logic [1:0] REQ_BLEND = 2'd0;
  localparam logic [1:0] REQ_FILL  = 2'd1;
  localparam logic [1:0] REQ_SHIFT = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [11:0] col_coord;
    logic signed [11:0] row_coord;
    logic signed [11:0] extent_cols;
    logic signed [11:0] extent_rows;
    logic signed [11:0] shift_amount;
    logic [15:0]        pixel_color;
    logic [7:0]         blend_alpha;
  } fbe_req_t;

  typedef struct packed {
    logic [15:0] read_pixel;
    logic        on_canvas;
  } fbe_rsp_t;

  // Channel blend: s = c*a + o*(255-a), then (s + (s>>8) + 1) >> 8.
  function automatic logic [5:0] blend_ch(input logic [5:0] c, input logic [5:0] o,
                                          input logic [7:0] a);
    logic [14:0] s;
    logic [15:0] t;
    s = 15'(c * a) + 15'(o * (8'd255 - a));
    t = 16'(s) + 16'(s >> 8) + 16'd1;
    return t[13:8];
  endfunction
endpackage

// ===== design/fbe_mem.sv =====
module fbe_mem import fbe_pkg::*; #(
  parameter int unsigned DEPTH = 76800,
  parameter int unsigned AW = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);
  logic [15:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== design/rgb565_framebuffer_blend_fill_shift.sv =====
// Frame engine over an RGB565 store with one write port and one registered read port.
// No-op requests, alpha 0/255 blends and off-canvas blends or reads go straight to the
// response state; on-canvas reads and partial-alpha blends read the store first (read, modify).
// Fill writes the clipped pixels row by row; shift loads each clipped row, then writes it back.
// One request at a time: the next request can be taken in the cycle after the result transfer.
// Reset clears the control state only; the frame store holds junk until written.
module rgb565_framebuffer_blend_fill_shift import fbe_pkg::*; #(
  parameter int unsigned FRAME_COLS = 320,
  parameter int unsigned FRAME_ROWS = 240
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fbe_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fbe_rsp_t out_data_o
);
  `include "rgb565_framebuffer_blend_fill_shift_assert.svh"

  localparam int unsigned DEPTH = FRAME_COLS * FRAME_ROWS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
  localparam int unsigned RW = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PIX   = 3'd1; // read issued, data on rdata in this state
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_SRD   = 3'd3; // load row into line buffer
  localparam logic [2:0] ST_SWR   = 3'd4; // write row back shifted
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]  state_q, state_d;
  fbe_req_t    req_q;
  logic [CW-1:0] col_q, c_from_q, c_to_q; // c_to inclusive
  logic [RW-1:0] row_q, r_last_q;
  logic        rd_pend_q;
  logic [CW-1:0] rd_col_q;
  logic [AW-1:0] pix_addr_q;
  logic [15:0] line_q [FRAME_COLS];
  // Shift write-back: phase 0 reads the line buffer, phase 1 writes the store.
  logic        ph_q;
  logic [15:0] lb_rd_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  fbe_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Clipping of the incoming request, signed 14-bit arithmetic.
  logic signed [13:0] x_s, y_s, ex_s, ey_s, x_end, y_end, f_from, f_to, r_first, r_end;
  logic signed [13:0] sh_s, sh_mag;
  logic in_pt, fill_ok, rows_ok, shift_ok;
  always_comb begin
    x_s = 14'(in_data_i.col_coord);
    y_s = 14'(in_data_i.row_coord);
    ex_s = 14'(in_data_i.extent_cols);
    ey_s = 14'(in_data_i.extent_rows);
    sh_s = 14'(in_data_i.shift_amount);
    x_end = x_s + ex_s;
    y_end = y_s + ey_s;
    f_from = (x_s < 0) ? 14'sd0 : x_s;
    f_to = (x_end > $signed(14'(FRAME_COLS))) ? $signed(14'(FRAME_COLS)) : x_end;
    r_first = (y_s < 0) ? 14'sd0 : y_s;
    r_end = (y_end > $signed(14'(FRAME_ROWS))) ? $signed(14'(FRAME_ROWS)) : y_end;
    sh_mag = (sh_s < 0) ? -sh_s : sh_s;
    in_pt = (x_s >= 0) && (y_s >= 0) && (x_s < $signed(14'(FRAME_COLS)))
         && (y_s < $signed(14'(FRAME_ROWS)));
    rows_ok = r_first < r_end;
    fill_ok = rows_ok && (f_from < f_to);
    shift_ok = rows_ok && (sh_s != 0) && (sh_mag < $signed(14'(FRAME_COLS)));
  end

  logic accept, out_fire;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  logic [AW-1:0] in_addr, row_base;
  assign in_addr = AW'(y_s[RW-1:0] * FRAME_COLS) + AW'(x_s[CW-1:0]);
  assign row_base = AW'(row_q * FRAME_COLS);

  // Shift source for the current write column.
  logic signed [13:0] src_s;
  logic src_ok;
  assign src_s = $signed({1'b0, 13'(col_q)}) - 14'(req_q.shift_amount);
  assign src_ok = (src_s >= 0) && (src_s < $signed(14'(FRAME_COLS)));

  // Blended value from read data.
  logic [15:0] blended;
  logic [5:0]  blend_r, blend_g, blend_b;
  always_comb begin
    blend_r = blend_ch({1'b0, req_q.pixel_color[15:11]}, {1'b0, rdata[15:11]},
                       req_q.blend_alpha);
    blend_g = blend_ch(req_q.pixel_color[10:5], rdata[10:5], req_q.blend_alpha);
    blend_b = blend_ch({1'b0, req_q.pixel_color[4:0]}, {1'b0, rdata[4:0]},
                       req_q.blend_alpha);
    blended = {blend_r[4:0], blend_g, blend_b[4:0]};
  end

  always_comb begin
    state_d = state_q;
    we = 1'b0; waddr = pix_addr_q; wdata = req_q.pixel_color;
    re = 1'b0; raddr = in_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.req_type)
            REQ_BLEND: begin
              if (in_pt && in_data_i.blend_alpha != 8'd0) begin
                if (in_data_i.blend_alpha == 8'd255) begin
                  we = 1'b1; waddr = in_addr; wdata = in_data_i.pixel_color;
                  state_d = ST_RESP;
                end else begin
                  re = 1'b1; state_d = ST_PIX;
                end
              end else begin
                state_d = ST_RESP;
              end
            end
            REQ_READ: begin
              re = in_pt; state_d = in_pt ? ST_PIX : ST_RESP;
            end
            REQ_FILL: state_d = fill_ok ? ST_FILL : ST_RESP;
            REQ_SHIFT: state_d = shift_ok ? ST_SRD : ST_RESP;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_PIX: begin
        if (req_q.req_type == REQ_BLEND) begin
          we = 1'b1; wdata = blended;
        end
        state_d = ST_RESP;
      end
      ST_FILL: begin
        we = 1'b1; waddr = row_base + AW'(col_q);
        if (col_q == c_to_q) begin
          if (row_q == r_last_q) state_d = ST_RESP;
        end
      end
      ST_SRD: begin
        re = 1'b1; raddr = row_base + AW'(col_q);
        if (col_q == CW'(FRAME_COLS - 1)) state_d = ST_SWR;
      end
      ST_SWR: begin
        if (!rd_pend_q && ph_q) begin
          we = 1'b1; waddr = row_base + AW'(col_q);
          wdata = src_ok ? lb_rd_q : req_q.pixel_color;
          if (col_q == CW'(FRAME_COLS - 1)) begin
            state_d = (row_q == r_last_q) ? ST_RESP : ST_SRD;
          end
        end
      end
      ST_RESP: if (out_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_pend_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      // Hold the last row read until it lands in the line buffer.
      rd_pend_q <= (state_q == ST_SRD);
      if (state_d == ST_RESP && state_q != ST_RESP) out_valid_o <= 1'b1;
      else if (out_fire) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
      pix_addr_q <= in_addr;
      row_q <= r_first[RW-1:0];
      r_last_q <= RW'(r_end - 14'sd1);
      col_q <= (in_data_i.req_type == REQ_FILL) ? f_from[CW-1:0] : '0;
      c_from_q <= f_from[CW-1:0];
      c_to_q <= CW'(f_to - 14'sd1);
      ph_q <= 1'b0;
      out_data_o <= '0;
    end
    if (rd_pend_q) line_q[rd_col_q] <= rdata;
    rd_col_q <= col_q;
    unique case (state_q)
      ST_PIX: if (req_q.req_type == REQ_READ) begin
        out_data_o.read_pixel <= rdata;
        out_data_o.on_canvas <= 1'b1;
      end
      ST_FILL: begin
        if (col_q == c_to_q) begin
          col_q <= c_from_q; row_q <= row_q + RW'(1);
        end else col_q <= col_q + CW'(1);
      end
      ST_SRD: col_q <= (col_q == CW'(FRAME_COLS - 1)) ? '0 : col_q + CW'(1);
      ST_SWR: if (!rd_pend_q) begin
        ph_q <= !ph_q;
        // Fetch the source pixel from the line buffer in the cycle before the write.
        if (!ph_q && src_ok) lb_rd_q <= line_q[src_s[CW-1:0]];
        if (ph_q) begin
          if (col_q == CW'(FRAME_COLS - 1)) begin
            col_q <= '0; row_q <= row_q + RW'(1);
          end else col_q <= col_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Checks on the sequencer.
  `FB_ASSERT_IMP(a_busy_no_accept, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o,
    "request taken while busy")
  `FB_ASSERT_IMP(a_valid_resp, clk_i, rst_ni, out_valid_o, state_q == ST_RESP,
    "result shown outside response state")
  `FB_ASSERT_NXT(a_fire_idle, clk_i, rst_ni, out_fire, state_q == ST_IDLE && !out_valid_o,
    "no return to idle after result transfer")
  `FB_ASSERT_IMP(a_nonread_zero, clk_i, rst_ni, out_valid_o && req_q.req_type != REQ_READ,
    out_data_o == '0, "non-read result not zero")
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import fbe_pkg::*;

  localparam int COLS = 320;
  localparam int ROWS = 240;

  // Tracks the expected frame contents and the queue of pending responses.
  class pixel_scoreboard;
    logic [15:0] pixels [COLS*ROWS];
    bit          written [COLS*ROWS];
    fbe_rsp_t    pending [$];
    int          errors;

    function automatic bit on_frame(int x, int y);
      return x >= 0 && y >= 0 && x < COLS && y < ROWS;
    endfunction

    function automatic logic [15:0] mix(logic [15:0] c, logic [15:0] o, int a);
      int r, g, b, s;
      s = int'(c[15:11]) * a + int'(o[15:11]) * (255 - a);
      r = (s + (s >> 8) + 1) >> 8;
      s = int'(c[10:5]) * a + int'(o[10:5]) * (255 - a);
      g = (s + (s >> 8) + 1) >> 8;
      s = int'(c[4:0]) * a + int'(o[4:0]) * (255 - a);
      b = (s + (s >> 8) + 1) >> 8;
      return {r[4:0], g[5:0], b[4:0]};
    endfunction

    // Apply an accepted request to the shadow frame and queue its response.
    function void note_request(fbe_req_t q);
      int x, y, h, w, d, first, last, from, to, idx;
      logic [15:0] line [COLS];
      bit line_w [COLS];
      fbe_rsp_t rsp;
      x = q.col_coord; y = q.row_coord; w = q.extent_cols; h = q.extent_rows;
      d = q.shift_amount;
      rsp = '0;
      first = y < 0 ? 0 : y;
      last = y + h > ROWS ? ROWS : y + h;
      case (q.req_type)
        REQ_BLEND: begin
          if (q.blend_alpha != 0 && on_frame(x, y)) begin
            idx = y * COLS + x;
            pixels[idx] = (q.blend_alpha == 8'd255) ? q.pixel_color :
                          mix(q.pixel_color, pixels[idx], q.blend_alpha);
            written[idx] = 1;
          end
        end
        REQ_FILL: begin
          from = x < 0 ? 0 : x;
          to = x + w > COLS ? COLS : x + w;
          for (int r = first; r < last; r++)
            for (int c = from; c < to; c++) begin
              pixels[r*COLS+c] = q.pixel_color;
              written[r*COLS+c] = 1;
            end
        end
        REQ_SHIFT: begin
          // Carry the written marks along with the pixels; vacated columns are written.
          if (d != 0 && d < COLS && d > -COLS)
            for (int r = first; r < last; r++) begin
              for (int c = 0; c < COLS; c++) begin
                if (c - d >= 0 && c - d < COLS) begin
                  line[c] = pixels[r*COLS+c-d];
                  line_w[c] = written[r*COLS+c-d];
                end else begin
                  line[c] = q.pixel_color;
                  line_w[c] = 1'b1;
                end
              end
              for (int c = 0; c < COLS; c++) begin
                pixels[r*COLS+c] = line[c];
                written[r*COLS+c] = line_w[c];
              end
            end
        end
        REQ_READ: begin
          if (on_frame(x, y)) begin
            rsp.read_pixel = pixels[y*COLS+x];
            rsp.on_canvas = 1'b1;
          end
        end
        default: ;
      endcase
      pending.push_back(rsp);
    endfunction

    function void check_response(fbe_rsp_t got);
      fbe_rsp_t want;
      if (pending.size() == 0) begin
        $error("response with nothing pending: read_pixel %h", got.read_pixel);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_pixel !== want.read_pixel) begin
        $error("read_pixel expected %h actual %h", want.read_pixel, got.read_pixel);
        errors++;
      end
      if (got.on_canvas !== want.on_canvas) begin
        $error("on_canvas expected %b actual %b", want.on_canvas, got.on_canvas);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_stall_o;
  fbe_req_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1;
  fbe_rsp_t out_data_o;

  pixel_scoreboard board = new();
  bit quiet = 0;      // no idling in the closing stretch

  rgb565_framebuffer_blend_fill_shift u_top (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // Send one request: hold valid until the transfer, with random gaps before.
  task automatic send_request(fbe_req_t q);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= q;
    board.note_request(q);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Draw a coordinate mostly on the canvas, sometimes anywhere.
  function automatic logic [11:0] pick_coord(int lim);
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    return 12'($urandom_range(0, lim - 1));
  endfunction

  // Pick a pixel that has already been written, so reads stay defined.
  function automatic bit pick_written(output int x, output int y);
    for (int i = 0; i < 40; i++) begin
      x = $urandom_range(0, COLS - 1);
      y = $urandom_range(0, ROWS - 1);
      if (board.written[y*COLS+x]) return 1;
    end
    return 0;
  endfunction

  function automatic fbe_req_t random_request();
    fbe_req_t q;
    int x, y, k;
    q = '0;
    q.pixel_color = 16'($urandom);
    q.blend_alpha = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                               : 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 40) begin
      q.req_type = REQ_BLEND;
      q.col_coord = pick_coord(COLS);
      q.row_coord = pick_coord(ROWS);
      // A partial blend needs a defined pixel underneath; make it opaque otherwise.
      x = q.col_coord;
      y = q.row_coord;
      if (board.on_frame(x, y) && !board.written[y*COLS+x] && q.blend_alpha != 8'd0)
        q.blend_alpha = 8'd255;
    end else if (k < 50) begin
      // Small rectangles keep the run short; the odd one has random extents.
      q.req_type = REQ_FILL;
      q.col_coord = 12'($urandom_range(0, COLS + 8) - 8);
      q.row_coord = 12'($urandom_range(0, ROWS + 8) - 8);
      q.extent_cols = $urandom_range(0, 15) == 0 ? 12'($urandom) : 12'($urandom_range(0, 12) - 2);
      q.extent_rows = $urandom_range(0, 15) == 0 ? 12'($urandom) : 12'($urandom_range(0, 6) - 2);
      if (q.extent_cols > 0 && q.extent_rows > 0 && q.extent_cols * q.extent_rows > 4000)
        q.extent_rows = 1;
    end else if (k < 53) begin
      q.req_type = REQ_SHIFT;
      q.row_coord = 12'($urandom_range(0, ROWS + 4) - 4);
      q.extent_rows = 12'($urandom_range(0, 5) - 2);
      case ($urandom_range(0, 3))
        0: q.shift_amount = 12'($urandom_range(0, 2048) - 1024);
        1: q.shift_amount = $urandom_range(0, 1) ? 12'(COLS) : -12'(COLS);
        default: q.shift_amount = 12'($urandom_range(0, 40) - 20);
      endcase
    end else begin
      q.req_type = REQ_READ;
      if ($urandom_range(0, 7) == 0 || !pick_written(x, y)) begin
        // Off-canvas read: always defined.
        q.col_coord = $urandom_range(0, 1) ? 12'($urandom_range(COLS, 2047))
                                           : 12'(-$urandom_range(1, 2048));
        q.row_coord = 12'($urandom);
      end else begin
        q.col_coord = 12'(x);
        q.row_coord = 12'(y);
      end
    end
    return q;
  endfunction

  function automatic fbe_req_t make_req(logic [1:0] t, int x, int y, int w, int h,
                                        int d, logic [15:0] c, logic [7:0] a);
    fbe_req_t q;
    q.req_type = t; q.col_coord = 12'(x); q.row_coord = 12'(y);
    q.extent_cols = 12'(w); q.extent_rows = 12'(h); q.shift_amount = 12'(d);
    q.pixel_color = c; q.blend_alpha = a;
    return q;
  endfunction

  // Response side: random stall bursts, check on each transfer.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall_i <= 1;
        repeat (n) begin
          @(posedge clk_i);
          if (out_valid_o && !out_stall_i) board.check_response(out_data_o);
        end
      end
      out_stall_i <= 0;
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_response(out_data_o);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed part: corners, clipping, alpha extremes, idle shifts, edge reads.
    send_request(make_req(REQ_FILL, -5, -5, 20, 10, 0, 16'hFFFF, 0));
    send_request(make_req(REQ_FILL, COLS - 3, ROWS - 2, 2047, 2047, 0, 16'h0000, 0));
    send_request(make_req(REQ_FILL, 10, 10, -2048, 5, 0, 16'h1234, 0));
    send_request(make_req(REQ_FILL, 2047, 2047, 4, 4, 0, 16'h1234, 0));
    send_request(make_req(REQ_FILL, -2048, -2048, 0, 0, 0, 16'h1234, 0));
    send_request(make_req(REQ_BLEND, 0, 0, 0, 0, 0, 16'h0000, 8'd0));
    send_request(make_req(REQ_BLEND, 1, 1, 0, 0, 0, 16'h0000, 8'd128));
    send_request(make_req(REQ_BLEND, 2, 2, 0, 0, 0, 16'hF81F, 8'd255));
    send_request(make_req(REQ_BLEND, 3, 3, 0, 0, 0, 16'h07E0, 8'd1));
    send_request(make_req(REQ_BLEND, -1, 3, 0, 0, 0, 16'h07E0, 8'd200));
    send_request(make_req(REQ_BLEND, COLS, ROWS, 0, 0, 0, 16'h07E0, 8'd255));
    send_request(make_req(REQ_SHIFT, 0, 0, 0, 2, 5, 16'hABCD, 0));
    send_request(make_req(REQ_SHIFT, 0, -1, 0, 3, -7, 16'h5555, 0));
    send_request(make_req(REQ_SHIFT, 0, 0, 0, 2, 0, 16'h1111, 0));
    send_request(make_req(REQ_SHIFT, 0, 0, 0, 2, COLS, 16'h1111, 0));
    send_request(make_req(REQ_SHIFT, 0, 0, 0, 2, -1024, 16'h1111, 0));
    send_request(make_req(REQ_SHIFT, 0, 0, 0, 2, COLS - 1, 16'h2222, 0));
    send_request(make_req(REQ_SHIFT, 0, 1, 0, -2048, 3, 16'h2222, 0));
    send_request(make_req(REQ_SHIFT, 0, ROWS - 1, 0, 2047, -2, 16'h3333, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 0, 16'hFFFF, 8'hFF));
    send_request(make_req(REQ_READ, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_READ, COLS - 1, ROWS - 1, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_READ, -2048, 2047, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_READ, 2047, -1, 0, 0, 0, 0, 0));
    // Hold off until all responses have drained.
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 950; i++) begin
      if (i == 850) quiet = 1;
      send_request(random_request());
    end
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0)
      $display("rgb565_framebuffer_blend_fill_shift: match");
    else
      $display("rgb565_framebuffer_blend_fill_shift: mismatch");
    $finish;
  end

  initial begin
    #300ms;
    $display("rgb565_framebuffer_blend_fill_shift: mismatch");
    $finish;
  end
endmodule
